// ----- design/bfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants of the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int MAX_PARTITIONS_DEF = 64;
	localparam int ADDR_WIDTH_DEF     = 32;

	localparam int TAG_W   = 16;
	localparam int REQ_W   = 24;
	localparam int PAGE_W  = 20;
	localparam int OUT_W   = 32;
	localparam int DIV_W   = REQ_W + 1;

	localparam logic [PAGE_W-1:0] PAGE_RESET = PAGE_W'(4096);

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_IGNORED  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_SPLIT_HI,
		S_SPLIT_LO,
		S_DIV,
		S_GROW_CHK,
		S_GROW_WR,
		S_GROW_EXTRA,
		S_FREE_WALK,
		S_FREE_TAIL,
		S_LF_SCAN,
		S_RESP
	} state_t;

endpackage

// ----- design/bfpa_div.sv -----
// ----------------------------------------------------------------------------
// bfpa_div
// Restoring divider, one quotient bit per cycle, for page rounding.
// ----------------------------------------------------------------------------
module bfpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bfpa_pkg::DIV_W-1:0]    num,
	input  logic [bfpa_pkg::PAGE_W-1:0]   den,
	output logic                          done,
	output logic [bfpa_pkg::DIV_W-1:0]    quo,
	output logic [bfpa_pkg::PAGE_W-1:0]   rem
);

	localparam int DW = bfpa_pkg::DIV_W;
	localparam int PW = bfpa_pkg::PAGE_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    num_q;
	logic [DW-1:0]    quo_q;
	logic [PW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PW:0]      trial;
	logic [PW:0]      diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, num_q[DW-1]};
		ge    = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- design/best_fit_partition_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Address-ordered partition table with best-fit allocate, page growth at the
// end and free-by-tag with coalescing. The table sits in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  req     | req_valid/req_ready, operation,       | in
//          | owner_tag, request_size               |
//  rsp     | rsp_valid/rsp_ready, status,          | out
//          | alloc_address, largest_free,          |
//          | pages_requested                       |
//  cfg     | cfg_wr_en, cfg_wr_data (page size)    | in
//
// One transaction at a time. Allocate: a best-fit scan, then the insert shift
// and split, a single write for an exact fit, or the page divider and growth
// writes, then a largest-free scan. Free: the compaction walk, then the
// largest-free scan. All scans are bound by the single table read port.
// Reset clears the count, end address and page total; no clearing pass.
// A stalled result holds in the output register; the next result waits for it.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator #(
	parameter int MAX_PARTITIONS = bfpa_pkg::MAX_PARTITIONS_DEF,
	parameter int ADDR_WIDTH     = bfpa_pkg::ADDR_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bfpa_pkg::PAGE_W-1:0]   cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          operation,
	input  logic [bfpa_pkg::TAG_W-1:0]    owner_tag,
	input  logic [bfpa_pkg::REQ_W-1:0]    request_size,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [1:0]                    status,
	output logic [bfpa_pkg::OUT_W-1:0]    alloc_address,
	output logic [bfpa_pkg::OUT_W-1:0]    largest_free,
	output logic [bfpa_pkg::OUT_W-1:0]    pages_requested
);

	localparam int MAXP = MAX_PARTITIONS;
	localparam int AW   = ADDR_WIDTH;
	localparam int IW   = $clog2(MAXP);
	localparam int CW   = $clog2(MAXP + 1);
	localparam int TW   = bfpa_pkg::TAG_W;
	localparam int RW   = bfpa_pkg::REQ_W;
	localparam int PW   = bfpa_pkg::PAGE_W;
	localparam int OW   = bfpa_pkg::OUT_W;
	localparam int DW   = bfpa_pkg::DIV_W;
	localparam int ZW   = (AW > RW) ? AW : RW;
	localparam int SW   = ((AW > DW) ? AW : DW) + 2;
	localparam int LW   = (AW > OW) ? AW : OW;

	bfpa_pkg::state_t  state_q, state_d;

	logic [TW-1:0] mem_tag  [MAXP];
	logic [AW-1:0] mem_size [MAXP];
	logic [AW-1:0] mem_base [MAXP];
	logic          mem_re, mem_we;
	logic [IW-1:0] mem_ra, mem_wa;
	logic [TW-1:0] wd_tag;
	logic [AW-1:0] wd_size, wd_base;
	logic [TW-1:0] rd_tag_q;
	logic [AW-1:0] rd_size_q, rd_base_q;

	logic [PW-1:0] page_size_q;
	logic [CW-1:0] count_q, idx_q, ridx_q, w_q, pick_q;
	logic [AW-1:0] end_q;
	logic [OW-1:0] total_q;
	logic          pend_q, found_q, held_v_q, rsp_valid_q, extend_q;
	logic [TW-1:0] tag_q, last_tag_q, held_tag_q;
	logic [RW-1:0] req_q, want_q;
	logic [AW-1:0] pick_size_q, pick_base_q, last_size_q, last_base_q;
	logic [AW-1:0] held_size_q, held_base_q, lf_q, addr_q;
	bfpa_pkg::status_t status_q, rsp_status_q;
	logic [OW-1:0] rsp_addr_q, rsp_lf_q, rsp_pages_q;

	logic          issue, issue_sh, fit_c, better_c, ext_c, merge_c, load_rsp;
	logic          same_c, full_g, ovf_g;
	logic [TW-1:0] t_c;
	logic [ZW-1:0] want_z;
	logic [RW-1:0] want_c;
	logic [PW-1:0] ps_c, extra_c;
	logic [CW:0]   need_sum;
	logic [SW-1:0] sum_g;
	logic [CW-1:0] grow_idx;
	logic [AW-1:0] grow_base;
	logic [OW:0]   tsum;
	logic [LW-1:0] lf_ext, addr_ext;
	logic          div_start, div_done;
	logic [DW-1:0] div_num, div_quo;
	logic [PW-1:0] div_rem;

	bfpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (ps_c),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		issue    = idx_q < count_q;
		issue_sh = idx_q > pick_q;
		fit_c    = (rd_tag_q == '0) && (ZW'(rd_size_q) >= ZW'(req_q));
		better_c = !found_q || (rd_size_q < pick_size_q);
		same_c   = pick_size_q == AW'(req_q);
		ext_c    = (count_q != '0) && (last_tag_q == '0);
		want_z   = ZW'(req_q) - (ext_c ? ZW'(last_size_q) : ZW'(0));
		want_c   = want_z[RW-1:0];
		ps_c     = (page_size_q == '0) ? PW'(1) : page_size_q;
		div_num  = DW'(want_c) + DW'(ps_c) - DW'(1);
		extra_c  = ps_c - PW'(1) - div_rem;
		need_sum = {1'b0, count_q} + (extend_q ? (CW+1)'(0) : (CW+1)'(1))
			+ ((extra_c != '0) ? (CW+1)'(1) : (CW+1)'(0));
		full_g   = need_sum > (CW+1)'(MAXP);
		sum_g    = SW'(end_q) + SW'(want_q) + SW'(extra_c);
		ovf_g    = sum_g >= (SW'(1) << AW);
		grow_idx = extend_q ? count_q - CW'(1) : count_q;
		grow_base = extend_q ? last_base_q : end_q;
		t_c      = (rd_tag_q == tag_q) ? TW'(0) : rd_tag_q;
		merge_c  = held_v_q && (held_tag_q == '0) && (t_c == '0);
		tsum     = {1'b0, total_q} + (OW+1)'(div_quo);
		load_rsp = !rsp_valid_q || rsp_ready;
		lf_ext   = LW'(lf_q);
		addr_ext = LW'(addr_q);
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_ra    = idx_q[IW-1:0];
		mem_we    = 1'b0;
		mem_wa    = '0;
		wd_tag    = '0;
		wd_size   = '0;
		wd_base   = '0;
		div_start = 1'b0;
		req_ready = state_q == bfpa_pkg::S_IDLE;
		case (state_q)
			bfpa_pkg::S_IDLE: begin
				if (req_valid) begin
					if (operation == bfpa_pkg::OP_FREE) begin
						state_d = (owner_tag == '0) ? bfpa_pkg::S_LF_SCAN
							: bfpa_pkg::S_FREE_WALK;
					end else if (request_size == '0 || owner_tag == '0) begin
						state_d = bfpa_pkg::S_LF_SCAN;
					end else begin
						state_d = bfpa_pkg::S_SCAN;
					end
				end
			end
			bfpa_pkg::S_SCAN: begin
				mem_re = issue;
				if (!pend_q && !issue) state_d = bfpa_pkg::S_DECIDE;
			end
			bfpa_pkg::S_DECIDE: begin
				if (found_q) begin
					if (same_c) begin
						mem_we  = 1'b1;
						mem_wa  = pick_q[IW-1:0];
						wd_tag  = tag_q;
						wd_size = pick_size_q;
						wd_base = pick_base_q;
						state_d = bfpa_pkg::S_LF_SCAN;
					end else if (count_q == CW'(MAXP)) begin
						state_d = bfpa_pkg::S_LF_SCAN;
					end else begin
						state_d = bfpa_pkg::S_SHIFT;
					end
				end else begin
					div_start = 1'b1;
					state_d   = bfpa_pkg::S_DIV;
				end
			end
			bfpa_pkg::S_SHIFT: begin
				mem_re = issue_sh;
				if (pend_q) begin
					mem_we  = 1'b1;
					mem_wa  = IW'(ridx_q + CW'(1));
					wd_tag  = rd_tag_q;
					wd_size = rd_size_q;
					wd_base = rd_base_q;
				end
				if (!pend_q && !issue_sh) state_d = bfpa_pkg::S_SPLIT_HI;
			end
			bfpa_pkg::S_SPLIT_HI: begin
				mem_we  = 1'b1;
				mem_wa  = IW'(pick_q + CW'(1));
				wd_size = pick_size_q - AW'(req_q);
				wd_base = pick_base_q + AW'(req_q);
				state_d = bfpa_pkg::S_SPLIT_LO;
			end
			bfpa_pkg::S_SPLIT_LO: begin
				mem_we  = 1'b1;
				mem_wa  = pick_q[IW-1:0];
				wd_tag  = tag_q;
				wd_size = AW'(req_q);
				wd_base = pick_base_q;
				state_d = bfpa_pkg::S_LF_SCAN;
			end
			bfpa_pkg::S_DIV: begin
				if (div_done) state_d = bfpa_pkg::S_GROW_CHK;
			end
			bfpa_pkg::S_GROW_CHK: begin
				state_d = (full_g || ovf_g) ? bfpa_pkg::S_LF_SCAN : bfpa_pkg::S_GROW_WR;
			end
			bfpa_pkg::S_GROW_WR: begin
				mem_we  = 1'b1;
				mem_wa  = grow_idx[IW-1:0];
				wd_tag  = tag_q;
				wd_size = AW'(req_q);
				wd_base = grow_base;
				state_d = (extra_c != '0) ? bfpa_pkg::S_GROW_EXTRA : bfpa_pkg::S_LF_SCAN;
			end
			bfpa_pkg::S_GROW_EXTRA: begin
				mem_we  = 1'b1;
				mem_wa  = count_q[IW-1:0];
				wd_size = AW'(extra_c);
				wd_base = addr_q + AW'(req_q);
				state_d = bfpa_pkg::S_LF_SCAN;
			end
			bfpa_pkg::S_FREE_WALK: begin
				mem_re = issue;
				if (pend_q && !merge_c && held_v_q) begin
					mem_we  = 1'b1;
					mem_wa  = w_q[IW-1:0];
					wd_tag  = held_tag_q;
					wd_size = held_size_q;
					wd_base = held_base_q;
				end
				if (!pend_q && !issue) state_d = bfpa_pkg::S_FREE_TAIL;
			end
			bfpa_pkg::S_FREE_TAIL: begin
				if (held_v_q) begin
					mem_we  = 1'b1;
					mem_wa  = w_q[IW-1:0];
					wd_tag  = held_tag_q;
					wd_size = held_size_q;
					wd_base = held_base_q;
				end
				state_d = bfpa_pkg::S_LF_SCAN;
			end
			bfpa_pkg::S_LF_SCAN: begin
				mem_re = issue;
				if (!pend_q && !issue) state_d = bfpa_pkg::S_RESP;
			end
			bfpa_pkg::S_RESP: begin
				if (load_rsp) state_d = bfpa_pkg::S_IDLE;
			end
			default: begin
				state_d = bfpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_tag[mem_wa]  <= wd_tag;
			mem_size[mem_wa] <= wd_size;
			mem_base[mem_wa] <= wd_base;
		end
		if (mem_re) begin
			rd_tag_q  <= mem_tag[mem_ra];
			rd_size_q <= mem_size[mem_ra];
			rd_base_q <= mem_base[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfpa_pkg::S_IDLE;
			page_size_q <= bfpa_pkg::PAGE_RESET;
			count_q     <= '0;
			end_q       <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			w_q         <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			held_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= mem_re;
			if (cfg_wr_en) page_size_q <= cfg_wr_data;
			if (state_d == bfpa_pkg::S_LF_SCAN && state_q != bfpa_pkg::S_LF_SCAN
				&& state_q != bfpa_pkg::S_IDLE) begin
				idx_q <= '0;
			end
			case (state_q)
				bfpa_pkg::S_IDLE: begin
					idx_q    <= '0;
					w_q      <= '0;
					found_q  <= 1'b0;
					held_v_q <= 1'b0;
				end
				bfpa_pkg::S_SCAN: begin
					if (mem_re) idx_q <= idx_q + CW'(1);
					if (pend_q && fit_c && better_c) found_q <= 1'b1;
				end
				bfpa_pkg::S_DECIDE: begin
					if (state_d == bfpa_pkg::S_SHIFT) idx_q <= count_q - CW'(1);
				end
				bfpa_pkg::S_SHIFT: begin
					if (mem_re) idx_q <= idx_q - CW'(1);
				end
				bfpa_pkg::S_SPLIT_LO: begin
					count_q <= count_q + CW'(1);
				end
				bfpa_pkg::S_GROW_WR: begin
					if (!extend_q) count_q <= count_q + CW'(1);
					end_q   <= sum_g[AW-1:0];
					total_q <= tsum[OW] ? '1 : tsum[OW-1:0];
				end
				bfpa_pkg::S_GROW_EXTRA: begin
					count_q <= count_q + CW'(1);
				end
				bfpa_pkg::S_FREE_WALK: begin
					if (mem_re) idx_q <= idx_q + CW'(1);
					if (pend_q && !merge_c) begin
						held_v_q <= 1'b1;
						if (held_v_q) w_q <= w_q + CW'(1);
					end
				end
				bfpa_pkg::S_FREE_TAIL: begin
					count_q <= w_q + CW'(held_v_q);
				end
				bfpa_pkg::S_LF_SCAN: begin
					if (mem_re) idx_q <= idx_q + CW'(1);
				end
				default: begin
				end
			endcase
			if (state_q == bfpa_pkg::S_RESP && load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= idx_q;
		if (state_d == bfpa_pkg::S_LF_SCAN && state_q != bfpa_pkg::S_LF_SCAN) begin
			lf_q <= '0;
		end
		case (state_q)
			bfpa_pkg::S_IDLE: begin
				tag_q    <= owner_tag;
				req_q    <= request_size;
				addr_q   <= '0;
				status_q <= (operation == bfpa_pkg::OP_ALLOC
					&& (request_size == '0 || owner_tag == '0))
					? bfpa_pkg::STAT_IGNORED : bfpa_pkg::STAT_DONE;
			end
			bfpa_pkg::S_SCAN: begin
				if (pend_q && fit_c && better_c) begin
					pick_q      <= ridx_q;
					pick_size_q <= rd_size_q;
					pick_base_q <= rd_base_q;
				end
				if (pend_q && ridx_q == count_q - CW'(1)) begin
					last_tag_q  <= rd_tag_q;
					last_size_q <= rd_size_q;
					last_base_q <= rd_base_q;
				end
			end
			bfpa_pkg::S_DECIDE: begin
				extend_q <= ext_c;
				want_q   <= want_c;
				if (found_q && same_c) begin
					addr_q <= pick_base_q;
				end else if (found_q && count_q == CW'(MAXP)) begin
					status_q <= bfpa_pkg::STAT_FULL;
				end
			end
			bfpa_pkg::S_SPLIT_LO: begin
				addr_q <= pick_base_q;
			end
			bfpa_pkg::S_GROW_CHK: begin
				if (full_g) begin
					status_q <= bfpa_pkg::STAT_FULL;
				end else if (ovf_g) begin
					status_q <= bfpa_pkg::STAT_OVERFLOW;
				end
			end
			bfpa_pkg::S_GROW_WR: begin
				addr_q <= grow_base;
			end
			bfpa_pkg::S_FREE_WALK: begin
				if (pend_q) begin
					if (merge_c) begin
						held_size_q <= held_size_q + rd_size_q;
					end else begin
						held_tag_q  <= t_c;
						held_size_q <= rd_size_q;
						held_base_q <= rd_base_q;
					end
				end
			end
			bfpa_pkg::S_LF_SCAN: begin
				if (pend_q && rd_tag_q == '0 && rd_size_q > lf_q) lf_q <= rd_size_q;
			end
			bfpa_pkg::S_RESP: begin
				if (load_rsp) begin
					rsp_status_q <= status_q;
					rsp_addr_q   <= addr_ext[OW-1:0];
					rsp_lf_q     <= (lf_ext > LW'({OW{1'b1}})) ? '1 : lf_ext[OW-1:0];
					rsp_pages_q  <= total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = rsp_status_q;
	assign alloc_address   = rsp_addr_q;
	assign largest_free    = rsp_lf_q;
	assign pages_requested = rsp_pages_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAXP))
		else $error("partition count beyond table depth");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_wa) <= count_q))
		else $error("table write past first unused entry");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == bfpa_pkg::S_DIV)
		else $error("divider finished outside page rounding");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == bfpa_pkg::S_RESP)
		else $error("response raised outside response state");

endmodule

// ----- tb/sv/best_fit_partition_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_checker
// Watches the request, response and page-size ports of the allocator, keeps
// its own copy of the partition table, predicts each response and compares
// the responses against the predictions in order.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bfpa_pkg::PAGE_W-1:0] cfg_wr_data,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  logic                        operation,
	input  logic [bfpa_pkg::TAG_W-1:0]  owner_tag,
	input  logic [bfpa_pkg::REQ_W-1:0]  request_size,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [1:0]                  status,
	input  logic [bfpa_pkg::OUT_W-1:0]  alloc_address,
	input  logic [bfpa_pkg::OUT_W-1:0]  largest_free,
	input  logic [bfpa_pkg::OUT_W-1:0]  pages_requested,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENT = bfpa_pkg::MAX_PARTITIONS_DEF;
	localparam longint unsigned SPACE_END = 64'd1 << bfpa_pkg::ADDR_WIDTH_DEF;
	localparam longint unsigned SAT32 = 64'hFFFF_FFFF;

	typedef struct packed {
		bfpa_pkg::status_t                st;
		logic [bfpa_pkg::OUT_W-1:0]       addr;
		logic [bfpa_pkg::OUT_W-1:0]       lf;
		logic [bfpa_pkg::OUT_W-1:0]       pages;
	} alloc_result_t;

	longint unsigned part_tag [N_ENT];
	longint unsigned part_size[N_ENT];
	longint unsigned part_base[N_ENT];
	int              part_count;
	longint unsigned top_addr;
	longint unsigned page_sum;
	longint unsigned page_bytes;
	alloc_result_t   expected_results[$];
	int              mismatches = 0;

	assign pending    = expected_results.size();
	assign fail_count = mismatches;

	function automatic longint unsigned widest_hole();
		longint unsigned best;
		best = 0;
		for (int i = 0; i < part_count; i++)
			if (part_tag[i] == 0 && part_size[i] > best)
				best = part_size[i];
		return (best > SAT32) ? SAT32 : best;
	endfunction

	function automatic bfpa_pkg::status_t place_block(longint unsigned tag,
			longint unsigned sz, output longint unsigned addr);
		longint unsigned ps, have, want, pages, extra, base;
		int pick, need;
		bit found, extend;
		ps = (page_bytes != 0) ? page_bytes : 1;
		pick = 0;
		found = 0;
		addr = 0;
		for (int i = 0; i < part_count; i++)
			if (part_tag[i] == 0 && part_size[i] >= sz)
				if (!found || part_size[i] < part_size[pick]) begin
					pick = i;
					found = 1;
				end
		if (found) begin
			if (part_size[pick] != sz) begin
				if (part_count >= N_ENT)
					return bfpa_pkg::STAT_FULL;
				for (int i = part_count; i > pick + 1; i--) begin
					part_tag[i]  = part_tag[i-1];
					part_size[i] = part_size[i-1];
					part_base[i] = part_base[i-1];
				end
				part_tag[pick+1]  = 0;
				part_size[pick+1] = part_size[pick] - sz;
				part_base[pick+1] = part_base[pick] + sz;
				part_size[pick]   = sz;
				part_count++;
			end
			part_tag[pick] = tag;
			addr = part_base[pick];
			return bfpa_pkg::STAT_DONE;
		end
		extend = part_count > 0 && part_tag[part_count-1] == 0;
		have   = extend ? part_size[part_count-1] : 0;
		want   = sz - have;
		pages  = (want + ps - 1) / ps;
		extra  = pages * ps - want;
		need   = (extend ? 0 : 1) + (extra != 0 ? 1 : 0);
		base   = extend ? part_base[part_count-1] : top_addr;
		if (part_count + need > N_ENT)
			return bfpa_pkg::STAT_FULL;
		if (top_addr + want + extra >= SPACE_END)
			return bfpa_pkg::STAT_OVERFLOW;
		if (!extend)
			part_count++;
		part_tag[part_count-1]  = tag;
		part_size[part_count-1] = sz;
		part_base[part_count-1] = base;
		if (extra != 0) begin
			part_tag[part_count]  = 0;
			part_size[part_count] = extra;
			part_base[part_count] = base + sz;
			part_count++;
		end
		top_addr += want + extra;
		page_sum = (page_sum + pages > SAT32) ? SAT32 : page_sum + pages;
		addr = base;
		return bfpa_pkg::STAT_DONE;
	endfunction

	function automatic void release_tag(longint unsigned tag);
		int w;
		longint unsigned t;
		w = 0;
		if (tag == 0)
			return;
		for (int i = 0; i < part_count; i++) begin
			t = (part_tag[i] == tag) ? 0 : part_tag[i];
			if (t == 0 && w > 0 && part_tag[w-1] == 0) begin
				part_size[w-1] += part_size[i];
			end else begin
				part_tag[w]  = t;
				part_size[w] = part_size[i];
				part_base[w] = part_base[i];
				w++;
			end
		end
		part_count = w;
	endfunction

	function automatic alloc_result_t predict_allocation(logic op,
			logic [bfpa_pkg::TAG_W-1:0] tag, logic [bfpa_pkg::REQ_W-1:0] sz);
		alloc_result_t r;
		longint unsigned a;
		a = 0;
		r.st = bfpa_pkg::STAT_DONE;
		if (bfpa_pkg::op_t'(op) == bfpa_pkg::OP_FREE)
			release_tag(tag);
		else if (sz == 0 || tag == 0)
			r.st = bfpa_pkg::STAT_IGNORED;
		else begin
			r.st = place_block(tag, sz, a);
			if (r.st != bfpa_pkg::STAT_DONE)
				a = 0;
		end
		r.addr  = a[bfpa_pkg::OUT_W-1:0];
		r.lf    = widest_hole();
		r.pages = page_sum[bfpa_pkg::OUT_W-1:0];
		return r;
	endfunction

	task automatic report(string field, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			part_count = 0;
			top_addr   = 0;
			page_sum   = 0;
			page_bytes = bfpa_pkg::PAGE_RESET;
			expected_results.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected response status", status, 0);
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st)          report("status", status, e.st);
					if (alloc_address !== e.addr) report("alloc_address", alloc_address, e.addr);
					if (largest_free !== e.lf)    report("largest_free", largest_free, e.lf);
					if (pages_requested !== e.pages)
						report("pages_requested", pages_requested, e.pages);
				end
			end
			if (req_valid && req_ready)
				expected_results.insert(expected_results.size(),
					predict_allocation(operation, owner_tag, request_size));
			if (cfg_wr_en)
				page_bytes = cfg_wr_data;
		end
	end

endmodule

// ----- tb/sv/best_fit_partition_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_tb
// Drives directed and random allocate and free transactions through the
// allocator under several page sizes and idle patterns; the checker predicts
// and compares every response.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE      = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 148;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [bfpa_pkg::PAGE_W-1:0] cfg_wr_data;
	logic                        req_valid;
	logic                        req_ready;
	logic                        operation;
	logic [bfpa_pkg::TAG_W-1:0]  owner_tag;
	logic [bfpa_pkg::REQ_W-1:0]  request_size;
	logic                        rsp_valid;
	logic                        rsp_ready;
	logic [1:0]                  status;
	logic [bfpa_pkg::OUT_W-1:0]  alloc_address;
	logic [bfpa_pkg::OUT_W-1:0]  largest_free;
	logic [bfpa_pkg::OUT_W-1:0]  pages_requested;
	int                          fail_count;
	int                          pending;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks = 0;
	int items_sent;
	int page_writes;
	int stall_cycles = 0;

	best_fit_partition_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .owner_tag(owner_tag), .request_size(request_size),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .alloc_address(alloc_address),
		.largest_free(largest_free), .pages_requested(pages_requested)
	);

	best_fit_partition_allocator_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .owner_tag(owner_tag), .request_size(request_size),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .alloc_address(alloc_address),
		.largest_free(largest_free), .pages_requested(pages_requested),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send(bfpa_pkg::op_t op, logic [bfpa_pkg::TAG_W-1:0] tag,
			logic [bfpa_pkg::REQ_W-1:0] sz);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		operation    <= op;
		owner_tag    <= tag;
		request_size <= sz;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic send_random();
		logic [bfpa_pkg::TAG_W-1:0] tag;
		logic [bfpa_pkg::REQ_W-1:0] sz;
		int pick;
		tag = ($urandom_range(9) == 0) ? bfpa_pkg::TAG_W'($urandom_range(65535))
			: bfpa_pkg::TAG_W'($urandom_range(6, 1));
		pick = $urandom_range(99);
		if (pick < 5)       sz = '0;
		else if (pick < 15) sz = bfpa_pkg::REQ_W'($urandom);
		else if (pick < 75) sz = bfpa_pkg::REQ_W'($urandom_range(4096, 1));
		else                sz = bfpa_pkg::REQ_W'($urandom_range(200000, 1));
		send(($urandom_range(99) < 30) ? bfpa_pkg::OP_FREE : bfpa_pkg::OP_ALLOC, tag, sz);
	endtask

	task automatic drain_and_set_page(logic [bfpa_pkg::PAGE_W-1:0] value);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		page_writes++;
	endtask

	// receiver: random idling plus one long hold-off
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** best_fit_partition_allocator: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [bfpa_pkg::PAGE_W-1:0] pages[7];
		pages = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd4096, 20'd777, 20'd3000};
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		req_valid    = 1'b0;
		operation    = 1'b0;
		owner_tag    = '0;
		request_size = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent    = 0;
		page_writes   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(bfpa_pkg::OP_ALLOC, 16'd1, 24'd0);
		send(bfpa_pkg::OP_ALLOC, 16'd0, 24'd100);
		send(bfpa_pkg::OP_FREE, 16'd0, 24'd0);
		send(bfpa_pkg::OP_ALLOC, 16'hFFFF, 24'hFFFFFF);
		send(bfpa_pkg::OP_ALLOC, 16'd1, 24'd1);
		send(bfpa_pkg::OP_ALLOC, 16'd2, 24'd4096);
		send(bfpa_pkg::OP_FREE, 16'hFFFF, 24'd0);
		send(bfpa_pkg::OP_ALLOC, 16'd3, 24'd100);
		send(bfpa_pkg::OP_ALLOC, 16'd4, 24'd100);
		send(bfpa_pkg::OP_ALLOC, 16'd5, 24'd4095);
		send(bfpa_pkg::OP_FREE, 16'd3, 24'd0);
		send(bfpa_pkg::OP_FREE, 16'd1, 24'd0);
		send(bfpa_pkg::OP_FREE, 16'h1234, 24'hFFFFFF);
		send(bfpa_pkg::OP_ALLOC, 16'h8000, 24'h800000);
		send(bfpa_pkg::OP_FREE, 16'd2, 24'hFFFFFF);
		send(bfpa_pkg::OP_FREE, 16'd4, 24'd0);

		for (int p = 0; p < 7; p++) begin
			drain_and_set_page(pages[p]);
			send_idle_pct = (p < 3) ? 38 : (p < 5) ? 79 : 0;
			recv_idle_pct = (p < 3) ? 79 : (p < 5) ? 38 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == 40)
					hold_asks++;
				if (p == 4 && i == 70) begin
					req_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_random();
			end
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Ran %0d allocate/free transactions over %0d page-size settings,", items_sent,
			page_writes + 1);
		$display("with sender/receiver idling, a long response hold-off and a full drain.");
		if (fail_count == 0)
			$display("** best_fit_partition_allocator: PASSED **");
		else
			$display("** best_fit_partition_allocator: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bfpa_pkg.sv
design/bfpa_div.sv
design/best_fit_partition_allocator.sv
tb/sv/best_fit_partition_allocator_checker.sv
tb/sv/best_fit_partition_allocator_tb.sv
